FILE: hdl/mavg_pkg.sv
package mavg_pkg;

   // Default sizing
   localparam int MAVG_WINDOW_LENGTH = 16;
   localparam int MAVG_CHANNEL_COUNT = 3;

   // Word field widths
   localparam int CHAN_W = 2;
   localparam int CODE_W = 12;
   localparam int MV_W   = 16;

   localparam logic [MV_W-1:0] FULL_SCALE_RESET = 16'd5000;

   // Millivolt scaling: floor(p / 4095) as (p * MV_RECIP) >> MV_RECIP_SHIFT,
   // exact for every p below 2^MV_PROD_W.
   localparam int          MV_PROD_W      = CODE_W + MV_W;
   localparam logic [63:0] CODE_FULL      = 64'd4095;
   localparam int          MV_RECIP_SHIFT = 40;
   localparam int          MV_RECIP_W     = 29;
   localparam logic [63:0] MV_RECIP_FULL  =
      ((64'd1 << MV_RECIP_SHIFT) + CODE_FULL - 64'd1) / CODE_FULL;
   localparam logic [MV_RECIP_W-1:0] MV_RECIP = MV_RECIP_FULL[MV_RECIP_W-1:0];

   // Result queue
   localparam int RSP_FIFO_DEPTH = 8;
   localparam int RSP_PTR_W      = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_CNT_W      = $clog2(RSP_FIFO_DEPTH + 1);

   typedef struct packed {
      logic [CHAN_W-1:0] result_channel;
      logic [CODE_W-1:0] average_code;
      logic [MV_W-1:0]   average_millivolts;
   } rsp_word_type;

   typedef struct packed {
      logic                 not_empty;
      logic [RSP_CNT_W-1:0] count;
   } fifo_status_type;

endpackage

FILE: hdl/mavg_ifs.sv
interface mavg_req_if import mavg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] channel_index;
   logic [CODE_W-1:0] sample_code;

   modport source (output valid, channel_index, sample_code, input ready);
   modport sink   (input valid, channel_index, sample_code, output ready);
endinterface

interface mavg_rsp_if import mavg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] result_channel;
   logic [CODE_W-1:0] average_code;
   logic [MV_W-1:0]   average_millivolts;

   modport source (output valid, result_channel, average_code, average_millivolts,
                   input ready);
   modport sink   (input valid, result_channel, average_code, average_millivolts,
                   output ready);
endinterface

FILE: hdl/multichannel_adc_moving_average_core.sv
// Channel   Dir  Handshake        Word
// req_chan  in   valid / ready    channel_index, sample_code
// rsp_chan  out  valid / ready    result_channel, average_code, average_millivolts
// csr       in   csr_wr_en        csr_wr_data = full scale in millivolts
//
// One sample word is taken per cycle while ready is high; each in-range word yields
// its result through ring read, sum update, window divide, scale multiply and the
// reciprocal multiply that feeds an 8-entry result queue.
// Ready depends only on queue plus pipeline occupancy, so a stalled rsp_chan
// holds results in the queue while samples flow until occupancy reaches its depth.
// Words with a channel number at or above the channel count are taken and dropped.
// Reset (synchronous) zeroes all sums, write positions and ring valid bits;
// no clearing pass is needed.
module multichannel_adc_moving_average_core import mavg_pkg::*; #(
   parameter int WINDOW_LENGTH = MAVG_WINDOW_LENGTH,
   parameter int CHANNEL_COUNT = MAVG_CHANNEL_COUNT
) (
   input  logic            clock,
   input  logic            reset,
   mavg_req_if.sink        req_chan,
   mavg_rsp_if.source      rsp_chan,
   input  logic            csr_wr_en,
   input  logic [MV_W-1:0] csr_wr_data
);

   localparam int POS_W   = $clog2(WINDOW_LENGTH);
   localparam int SUM_W   = CODE_W + POS_W;
   localparam int CHI_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int ENTRIES = CHANNEL_COUNT * WINDOW_LENGTH;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int OCC_W   = $clog2(RSP_FIFO_DEPTH + 5);
   localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW_LENGTH * 4095);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LENGTH - 1);
   localparam int MV_FULL_W = MV_PROD_W + MV_RECIP_W;

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   logic [MV_W-1:0] fs_mv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_mv_ff <= FULL_SCALE_RESET;
      end else if (csr_wr_en) begin
         fs_mv_ff <= csr_wr_data;
      end
   end

   // ------------------------------------------------------------------
   // Intake: flow control by occupancy, drop out-of-range channels
   // ------------------------------------------------------------------
   logic                  s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   fifo_status_type       fifo_st;
   logic [OCC_W-1:0]      occ;
   logic                  req_acc;
   logic                  ch_ok;
   logic                  take;
   logic [CHI_W-1:0]      req_idx;
   logic [POS_W-1:0]      cur_pos;
   logic [POS_W-1:0]      next_pos;
   logic [ADDR_W-1:0]     ring_addr;

   assign occ = OCC_W'(fifo_st.count) + OCC_W'(s1_vld_ff) + OCC_W'(s2_vld_ff)
              + OCC_W'(s3_vld_ff) + OCC_W'(s4_vld_ff);
   assign req_chan.ready = (occ < OCC_W'(RSP_FIFO_DEPTH));

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign ch_ok    = (int'(req_chan.channel_index) < CHANNEL_COUNT);
   assign take     = req_acc && ch_ok;
   assign req_idx  = CHI_W'(req_chan.channel_index);

   // ------------------------------------------------------------------
   // Per-channel write positions
   // ------------------------------------------------------------------
   logic [POS_W-1:0] pos_ff [CHANNEL_COUNT];

   assign cur_pos   = pos_ff[req_idx];
   assign next_pos  = (cur_pos == POS_LAST) ? '0 : cur_pos + POS_W'(1);
   assign ring_addr = ADDR_W'(int'(req_idx) * WINDOW_LENGTH + int'(cur_pos));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            pos_ff[i] <= '0;
         end
      end else if (take) begin
         pos_ff[req_idx] <= next_pos;
      end
   end

   // ------------------------------------------------------------------
   // Sample ring: read-first memory, the replaced sample comes out registered in
   // the cycle after the write. Valid bits stand in for the all-zero reset contents.
   // ------------------------------------------------------------------
   logic [CODE_W-1:0] ring_ff [ENTRIES];
   logic [CODE_W-1:0] ring_rd_ff;
   logic [ENTRIES-1:0] ring_vld_ff;
   logic              ring_old_vld_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         ring_ff[ring_addr] <= req_chan.sample_code;
         ring_rd_ff         <= ring_ff[ring_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
      end else if (take) begin
         ring_vld_ff[ring_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ring_old_vld_ff <= ring_vld_ff[ring_addr];
      end
   end

   // ------------------------------------------------------------------
   // Stage 1 -> 2: running sum update
   // ------------------------------------------------------------------
   logic [CHI_W-1:0]  s1_idx_ff;
   logic [CHAN_W-1:0] s1_ch_ff;
   logic [CODE_W-1:0] s1_code_ff;
   logic [SUM_W-1:0]  sum_ff [CHANNEL_COUNT];
   logic [CODE_W-1:0] old_code;
   logic [SUM_W-1:0]  sum_in;
   logic [SUM_W-1:0]  s2_sum_ff;
   logic [CHAN_W-1:0] s2_ch_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         s1_idx_ff  <= req_idx;
         s1_ch_ff   <= req_chan.channel_index;
         s1_code_ff <= req_chan.sample_code;
      end
   end

   // A never-written entry reads as zero
   assign old_code = ring_old_vld_ff ? ring_rd_ff : '0;
   assign sum_in   = sum_ff[s1_idx_ff] - SUM_W'(old_code) + SUM_W'(s1_code_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            sum_ff[i] <= '0;
         end
      end else if (s1_vld_ff) begin
         sum_ff[s1_idx_ff] <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         s2_sum_ff <= sum_in;
         s2_ch_ff  <= s1_ch_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2 -> 3: divide by window length (shift, or reciprocal multiply)
   // ------------------------------------------------------------------
   logic [CODE_W-1:0] avg_in;
   logic [CODE_W-1:0] s3_avg_ff;
   logic [CHAN_W-1:0] s3_ch_ff;

   if ((WINDOW_LENGTH & (WINDOW_LENGTH - 1)) == 0) begin : g_div_shift
      assign avg_in = s2_sum_ff[SUM_W-1 -: CODE_W];
   end else begin : g_div_recip
      localparam int          DIV_SHIFT   = SUM_W + POS_W;
      localparam int          DIV_RECIP_W = SUM_W + 2;
      localparam int          DIV_PROD_W  = SUM_W + DIV_RECIP_W;
      localparam logic [63:0] DIV_RECIP_FULL =
         ((64'd1 << DIV_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
      localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_FULL[DIV_RECIP_W-1:0];
      logic [DIV_PROD_W-1:0] div_prod;

      assign div_prod = DIV_PROD_W'(s2_sum_ff) * DIV_PROD_W'(DIV_RECIP);
      assign avg_in   = div_prod[DIV_SHIFT +: CODE_W];
   end

   always_ff @(posedge clock) begin
      if (s2_vld_ff) begin
         s3_avg_ff <= avg_in;
         s3_ch_ff  <= s2_ch_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3 -> 4: scale by full-scale millivolts
   // ------------------------------------------------------------------
   logic [MV_PROD_W-1:0] s4_prod_ff;
   logic [CODE_W-1:0]    s4_avg_ff;
   logic [CHAN_W-1:0]    s4_ch_ff;

   always_ff @(posedge clock) begin
      if (s3_vld_ff) begin
         s4_prod_ff <= MV_PROD_W'(s3_avg_ff) * MV_PROD_W'(fs_mv_ff);
         s4_avg_ff  <= s3_avg_ff;
         s4_ch_ff   <= s3_ch_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4 -> queue: divide by 4095 via reciprocal
   // ------------------------------------------------------------------
   logic [MV_FULL_W-1:0] mv_full;
   rsp_word_type         push_word;
   rsp_word_type         head_word;
   logic                 rsp_pop;

   assign mv_full = MV_FULL_W'(s4_prod_ff) * MV_FULL_W'(MV_RECIP);

   assign push_word.result_channel     = s4_ch_ff;
   assign push_word.average_code       = s4_avg_ff;
   assign push_word.average_millivolts = mv_full[MV_RECIP_SHIFT +: MV_W];

   // Pipeline valids: advance every cycle, never stall
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= take;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   assign rsp_pop = rsp_chan.valid && rsp_chan.ready;

   mavg_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (s4_vld_ff),
      .push_word (push_word),
      .pop_en    (rsp_pop),
      .head_word (head_word),
      .status    (fifo_st)
   );

   assign rsp_chan.valid              = fifo_st.not_empty;
   assign rsp_chan.result_channel     = head_word.result_channel;
   assign rsp_chan.average_code       = head_word.average_code;
   assign rsp_chan.average_millivolts = head_word.average_millivolts;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ <= OCC_W'(RSP_FIFO_DEPTH))
      else $error("occupancy above queue depth");

   a_take_enters: assert property (@(posedge clock) disable iff (reset)
      take |=> s1_vld_ff)
      else $error("accepted in-range word lost at intake");

   a_drop_out_of_range: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !ch_ok) |=> !s1_vld_ff)
      else $error("out-of-range channel entered pipeline");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> (s2_sum_ff <= SUM_MAX))
      else $error("window sum beyond window capacity");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s4_vld_ff |-> (fifo_st.count < RSP_CNT_W'(RSP_FIFO_DEPTH)))
      else $error("push into full result queue");

endmodule

FILE: hdl/mavg_rsp_fifo.sv
module mavg_rsp_fifo import mavg_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_en,
   input  rsp_word_type    push_word,
   input  logic            pop_en,
   output rsp_word_type    head_word,
   output fifo_status_type status
);

   rsp_word_type         mem_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_en ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_en ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push_en) - RSP_CNT_W'(pop_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign head_word        = mem_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.count     = count_ff;

endmodule

FILE: verif/tb_multichannel_adc_moving_average_core.sv
`timescale 1ns / 100ps

module tb_multichannel_adc_moving_average_core;
   import mavg_pkg::*;

   // Timing and run shape
   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 8;
   localparam int IDLE_PERCENT   = 19;
   localparam int DRAIN_CYCLES   = 8;     // pipeline depth plus margin
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
   localparam int HOLD_AFTER     = 400;   // results seen before the long receiver stall
   localparam int HOLD_CYCLES    = 80;
   localparam int PHASES         = 7;
   localparam int PHASE_ITEMS    = 230;
   localparam int DIRECTED_ROWS  = 13;

   // Block sizing
   localparam int WINDOW          = MAVG_WINDOW_LENGTH;
   localparam int CHANNELS        = MAVG_CHANNEL_COUNT;
   localparam int CODE_FULL_COUNT = (1 << CODE_W) - 1;
   localparam logic [CHAN_W-1:0] UNUSED_CHANNEL = CHAN_W'(CHANNELS);
   localparam logic [CODE_W-1:0] CODE_TOP       = CODE_W'(CODE_FULL_COUNT);
   localparam logic [MV_W-1:0]   SCALE_TOP      = {MV_W{1'b1}};

   typedef enum logic {ROW_SAMPLE, ROW_FULL_SCALE} row_kind_type;

   // One line of the directed table. A ROW_SAMPLE row sends value as the sample
   // code count times; typed rows carry the result read off by hand for the
   // last of those words. A ROW_FULL_SCALE row writes value to the register.
   typedef struct packed {
      row_kind_type      kind;
      logic [CHAN_W-1:0] chan;
      logic [MV_W-1:0]   value;
      logic [4:0]        count;
      logic              typed;
      logic [CODE_W-1:0] want_avg;
      logic [MV_W-1:0]   want_mv;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [MV_W-1:0] csr_wr_data;

   mavg_req_if req_bus ();
   mavg_rsp_if rsp_bus ();

   multichannel_adc_moving_average_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Filter shadow: per-channel sample ring, write slot and running sum, plus
   // the full-scale register as last written.
   logic [CODE_W-1:0] ring_samples [CHANNELS][WINDOW] = '{default: '0};
   int unsigned       write_slot   [CHANNELS]         = '{default: 0};
   int unsigned       window_total [CHANNELS]         = '{default: 0};
   logic [MV_W-1:0]   full_scale_mv = FULL_SCALE_RESET;

   rsp_word_type     expected_averages [$];
   directed_row_type directed_rows [DIRECTED_ROWS];

   int fault_count  = 0;
   int results_seen = 0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;
   bit burst_mode   = 1'b0;
   int quiet_cycles = 0;

   // Replace the oldest sample of the channel, refresh its sum and form the
   // truncated average and its millivolt value.
   function automatic rsp_word_type update_window(input logic [CHAN_W-1:0] ch,
                                                  input logic [CODE_W-1:0] code);
      int unsigned slot;
      logic [CODE_W+MV_W-1:0] scaled;
      rsp_word_type w;
      slot = write_slot[ch];
      window_total[ch] = window_total[ch] - ring_samples[ch][slot] + code;
      ring_samples[ch][slot] = code;
      write_slot[ch] = (slot + 1 == WINDOW) ? 0 : slot + 1;
      w.result_channel = ch;
      w.average_code   = CODE_W'(window_total[ch] / WINDOW);
      scaled = w.average_code * full_scale_mv;
      w.average_millivolts = MV_W'(scaled / CODE_FULL_COUNT);
      return w;
   endfunction

   // Offer one word and hold it until taken. Valid stays high afterward so a
   // back-to-back word needs no second assignment in the same step.
   task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [CODE_W-1:0] code,
                              input logic typed, input rsp_word_type typed_word);
      rsp_word_type w;
      req_bus.valid         <= 1'b1;
      req_bus.channel_index <= ch;
      req_bus.sample_code   <= code;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // Words on an unused channel are taken and dropped: no result, no state change.
      if (ch < CHANNELS) begin
         w = update_window(ch, code);
         expected_averages.push_back(typed ? typed_word : w);
      end
   endtask

   // Drop valid for a random number of cycles, unless in the no-gap stretch.
   task automatic sender_gap();
      while (!burst_mode && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Write the full-scale register only with the pipe empty: wait for every
   // pending result, then wait out the drain tail.
   task automatic write_full_scale(input logic [MV_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (expected_averages.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      full_scale_mv = value;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CODE_W-1:0] pick_code();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return '0;
      if (roll == 1) return CODE_TOP;
      return CODE_W'($urandom_range(CODE_FULL_COUNT));
   endfunction

   function automatic logic [CHAN_W-1:0] pick_channel();
      if ($urandom_range(7) == 0) return UNUSED_CHANNEL;
      return CHAN_W'($urandom_range(CHANNELS - 1));
   endfunction

   // Result side: check each taken word against the oldest expectation, then
   // pick ready for the next cycle. One long stall is forced once enough
   // results have gone by, so the queue fills and the input backs up.
   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (expected_averages.size() == 0) begin
            $error("unexpected result word: channel %0d average %0d millivolts %0d",
                   rsp_bus.result_channel, rsp_bus.average_code,
                   rsp_bus.average_millivolts);
            fault_count++;
         end else begin
            rsp_word_type want;
            want = expected_averages.pop_front();
            if (rsp_bus.result_channel !== want.result_channel) begin
               $error("result_channel: expected %0d, actual %0d",
                      want.result_channel, rsp_bus.result_channel);
               fault_count++;
            end
            if (rsp_bus.average_code !== want.average_code) begin
               $error("average_code: expected %0d, actual %0d",
                      want.average_code, rsp_bus.average_code);
               fault_count++;
            end
            if (rsp_bus.average_millivolts !== want.average_millivolts) begin
               $error("average_millivolts: expected %0d, actual %0d",
                      want.average_millivolts, rsp_bus.average_millivolts);
               fault_count++;
            end
         end
      end

      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= burst_mode || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: end the run if no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      directed_row_type row;
      rsp_word_type  typed_word;
      logic [CHAN_W-1:0] ch;
      logic [CODE_W-1:0] code;
      logic [MV_W-1:0]   scale;
      int sent;

      // Hold every input at a known value from time zero.
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_wr_data           <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.channel_index <= '0;
      req_bus.sample_code   <= '0;

      directed_rows = '{
         // a zero sample straight out of reset averages to zero
         '{ROW_SAMPLE,     2'd0,           16'd0,    5'd1,  1'b1, 12'd0,    16'd0},
         // an unused channel number is dropped
         '{ROW_SAMPLE,     UNUSED_CHANNEL, 16'd4095, 5'd1,  1'b0, 12'd0,    16'd0},
         // early averages still include the cleared ring
         '{ROW_SAMPLE,     2'd1,           16'd4095, 5'd1,  1'b0, 12'd0,    16'd0},
         '{ROW_SAMPLE,     2'd2,           16'd4095, 5'd15, 1'b0, 12'd0,    16'd0},
         // full window of top codes reads back as full scale
         '{ROW_SAMPLE,     2'd2,           16'd4095, 5'd1,  1'b1, 12'd4095, 16'd5000},
         '{ROW_FULL_SCALE, 2'd0,           SCALE_TOP, 5'd1, 1'b0, 12'd0,    16'd0},
         '{ROW_SAMPLE,     2'd2,           16'd4095, 5'd1,  1'b1, 12'd4095, SCALE_TOP},
         '{ROW_FULL_SCALE, 2'd0,           16'd0,    5'd1,  1'b0, 12'd0,    16'd0},
         '{ROW_SAMPLE,     2'd1,           16'hAAA,  5'd1,  1'b0, 12'd0,    16'd0},
         '{ROW_SAMPLE,     2'd0,           16'h555,  5'd1,  1'b0, 12'd0,    16'd0},
         '{ROW_SAMPLE,     UNUSED_CHANNEL, 16'd0,    5'd1,  1'b0, 12'd0,    16'd0},
         // scale of 4095 makes millivolts equal the average code
         '{ROW_FULL_SCALE, 2'd0,           16'd4095, 5'd1,  1'b0, 12'd0,    16'd0},
         '{ROW_SAMPLE,     2'd2,           16'd0,    5'd1,  1'b0, 12'd0,    16'd0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = directed_rows[r];
         if (row.kind == ROW_FULL_SCALE) begin
            write_full_scale(row.value);
         end else begin
            typed_word = {row.chan, row.want_avg, row.want_mv};
            for (int k = 0; k < row.count; k++) begin
               sender_gap();
               send_sample(row.chan, row.value[CODE_W-1:0],
                           row.typed && (k == row.count - 1), typed_word);
            end
         end
      end

      // Random phases, each at its own full scale; extremes first. Phase two
      // runs with no gaps on either side.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: scale = FULL_SCALE_RESET;
            1: scale = 16'd1;
            2: scale = SCALE_TOP;
            3: scale = 16'd0;
            4: scale = 16'd4095;
            default: scale = MV_W'($urandom_range(65535));
         endcase
         write_full_scale(scale);
         burst_mode <= (phase == 2);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(19) == 0) begin
               // Drive one channel at a steady level for over a full window.
               ch   = CHAN_W'($urandom_range(CHANNELS - 1));
               code = pick_code();
               repeat (WINDOW + 1) begin
                  sender_gap();
                  send_sample(ch, code, 1'b0, '0);
               end
               sent += WINDOW + 1;
            end else begin
               ch = pick_channel();
               sender_gap();
               send_sample(ch, pick_code(), 1'b0, '0);
               if (ch < CHANNELS) sent++;
            end
         end
      end

      // Drain: wait for every pending result, then a short tail.
      req_bus.valid <= 1'b0;
      burst_mode    <= 1'b0;
      while (expected_averages.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_averages.size() != 0) begin
         $error("%0d expected results never arrived", expected_averages.size());
         fault_count++;
      end

      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/mavg_pkg.sv
hdl/mavg_ifs.sv
hdl/mavg_rsp_fifo.sv
hdl/multichannel_adc_moving_average_core.sv
verif/tb_multichannel_adc_moving_average_core.sv
